// ----- rtl/thlp_pkg.sv -----
`timescale 1ns / 1ps
// types, character codes and the hex digit decoder for the tagged hex load parser
// no dependencies
package thlp_pkg;

    localparam int DESC_MAX_DEFAULT = 250;

    // tag and control characters
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_B     = 8'h42;  // 'B'
    localparam logic [7:0] CH_K     = 8'h4B;  // 'K'
    localparam logic [7:0] CH_7     = 8'h37;  // '7'
    localparam logic [7:0] CH_8     = 8'h38;  // '8'
    localparam logic [7:0] CH_9     = 8'h39;  // '9'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_0     = 8'h30;  // '0'
    localparam logic [7:0] CH_F     = 8'h46;  // 'F'
    localparam logic [7:0] CH_LF    = 8'h0A;  // newline

    localparam logic [15:0] DESC_LEN_BIAS = 16'd5;   // length word counts 5 header chars
    localparam logic [3:0]  HDR_NAME_LEN  = 4'd8;    // free chars after the header word
    localparam logic [3:0]  WORD_DIGITS   = 4'd4;
    localparam logic [3:0]  BYTE_DIGITS   = 4'd2;

    typedef enum logic [3:0] {
        PH_TAG   = 4'd0,
        PH_STAR  = 4'd1,
        PH_BDATA = 4'd2,
        PH_HDRW  = 4'd3,
        PH_HDRN  = 4'd4,
        PH_CSUM  = 4'd5,
        PH_SKIPW = 4'd6,
        PH_ADDR  = 4'd7,
        PH_FNL   = 4'd8,
        PH_KLEN  = 4'd9,
        PH_KBODY = 4'd10,
        PH_DRAIN = 4'd11
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_DESC     = 3'd1,
        KIND_DESC_END = 3'd2,
        KIND_EOI      = 3'd3,
        KIND_ERROR    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TAG       = 3'd1,
        ERR_CHECKSUM  = 3'd2,
        ERR_NEWLINE   = 3'd3,
        ERR_DESC      = 3'd4,
        ERR_HEX       = 3'd5,
        ERR_TRUNCATED = 3'd6
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] byte_address;
        logic [7:0]  byte_value;
        err_t        error_code;
        logic [15:0] sum_expected;
        logic [15:0] sum_found;
    } result_t;

    typedef struct packed {
        logic halted;
    } status_t;

    // bit 4 set: not a hex digit; bits 3:0 the digit value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h41 + 8'd10)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

endpackage

// ----- rtl/thlp_core.sv -----
`timescale 1ns / 1ps
// parser state registers and the per-character step logic
// depends on thlp_pkg
module thlp_core #(
    parameter int DESC_MAX = thlp_pkg::DESC_MAX_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        ch,
    input  logic              eoi,
    output logic              res_valid,
    output thlp_pkg::result_t res,
    output thlp_pkg::status_t status
);
    import thlp_pkg::*;

    localparam logic [15:0] DescMaxW = 16'(DESC_MAX);

    phase_t      phase_reg, phase_next;
    logic [3:0]  digit_reg, digit_next;
    logic [15:0] accum_reg, accum_next;
    logic [31:0] addr_reg, addr_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] snap_reg, snap_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] index_reg, index_next;
    logic        halted_reg, halted_next;

    logic [4:0]  hex;
    logic [15:0] accum_sh;
    logic [3:0]  digit_inc;
    logic [15:0] remain_dec;
    logic [15:0] index_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TAG;
            digit_reg  <= '0;
            accum_reg  <= '0;
            addr_reg   <= '0;
            sum_reg    <= '0;
            snap_reg   <= '0;
            remain_reg <= '0;
            index_reg  <= '0;
            halted_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            digit_reg  <= digit_next;
            accum_reg  <= accum_next;
            addr_reg   <= addr_next;
            sum_reg    <= sum_next;
            snap_reg   <= snap_next;
            remain_reg <= remain_next;
            index_reg  <= index_next;
            halted_reg <= halted_next;
        end
    end

    always_comb begin
        hex        = hex_decode(ch);
        accum_sh   = {accum_reg[11:0], hex[3:0]};
        digit_inc  = digit_reg + 4'd1;
        remain_dec = remain_reg - 16'd1;
        index_inc  = index_reg + 16'd1;

        phase_next  = phase_reg;
        digit_next  = digit_reg;
        accum_next  = accum_reg;
        addr_next   = addr_reg;
        snap_next   = snap_reg;
        remain_next = remain_reg;
        index_next  = index_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (eoi || ch == CH_LF) begin
            sum_next = '0;
        end else begin
            sum_next = sum_reg + {8'd0, ch};
        end

        if (halted_reg) begin
            sum_next = sum_reg;
        end else begin
            case (phase_reg)
                PH_TAG: begin
                    if (eoi) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_EOI;
                        digit_next = '0;
                    end else begin
                        accum_next = '0;
                        digit_next = '0;
                        case (ch)
                            CH_STAR:  phase_next = PH_STAR;
                            CH_B:     phase_next = PH_BDATA;
                            CH_0:     phase_next = PH_HDRW;
                            CH_7: begin
                                snap_next  = 16'd0 - sum_next;
                                phase_next = PH_CSUM;
                            end
                            CH_8:     phase_next = PH_SKIPW;
                            CH_9:     phase_next = PH_ADDR;
                            CH_F:     phase_next = PH_FNL;
                            CH_K:     phase_next = PH_KLEN;
                            CH_COLON: phase_next = PH_DRAIN;
                            default: begin
                                halted_next    = 1'b1;
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_TAG;
                                res.byte_value = ch;
                            end
                        endcase
                    end
                end

                PH_STAR, PH_BDATA, PH_HDRW, PH_CSUM, PH_SKIPW, PH_ADDR, PH_KLEN: begin
                    if (eoi) begin
                        halted_next    = 1'b1;
                        phase_next     = PH_TAG;
                        digit_next     = '0;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_TRUNCATED;
                    end else if (hex[4]) begin
                        halted_next    = 1'b1;
                        phase_next     = PH_TAG;
                        digit_next     = '0;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_HEX;
                        res.byte_value = ch;
                    end else begin
                        accum_next = accum_sh;
                        digit_next = digit_inc;
                        if (phase_reg == PH_STAR || phase_reg == PH_BDATA) begin
                            // a byte is out at every second digit
                            if (digit_inc == BYTE_DIGITS || digit_inc == WORD_DIGITS) begin
                                res_valid        = 1'b1;
                                res.kind         = KIND_DATA;
                                res.byte_address = addr_reg;
                                res.byte_value   = accum_sh[7:0];
                                addr_next        = addr_reg + 32'd1;
                                if (phase_reg == PH_STAR || digit_inc == WORD_DIGITS) begin
                                    phase_next = PH_TAG;
                                end
                            end
                        end else if (digit_inc == WORD_DIGITS) begin
                            digit_next = '0;
                            phase_next = PH_TAG;
                            case (phase_reg)
                                PH_HDRW: phase_next = PH_HDRN;
                                PH_CSUM: begin
                                    if (accum_sh != snap_reg) begin
                                        halted_next      = 1'b1;
                                        res_valid        = 1'b1;
                                        res.kind         = KIND_ERROR;
                                        res.error_code   = ERR_CHECKSUM;
                                        res.sum_expected = snap_reg;
                                        res.sum_found    = accum_sh;
                                    end
                                end
                                PH_ADDR: addr_next = {15'd0, accum_sh, 1'b0};
                                PH_KLEN: begin
                                    if (accum_sh < DESC_LEN_BIAS) begin
                                        halted_next    = 1'b1;
                                        res_valid      = 1'b1;
                                        res.kind       = KIND_ERROR;
                                        res.error_code = ERR_DESC;
                                    end else begin
                                        remain_next = accum_sh - DESC_LEN_BIAS;
                                        index_next  = '0;
                                        if (accum_sh == DESC_LEN_BIAS) begin
                                            // empty description ends at once
                                            res_valid = 1'b1;
                                            res.kind  = KIND_DESC_END;
                                        end else begin
                                            phase_next = PH_KBODY;
                                        end
                                    end
                                end
                                default: phase_next = PH_TAG;
                            endcase
                        end
                    end
                end

                PH_HDRN: begin
                    if (eoi) begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_EOI;
                        phase_next = PH_TAG;
                        digit_next = '0;
                    end else if (digit_inc >= HDR_NAME_LEN) begin
                        digit_next = '0;
                        phase_next = PH_TAG;
                    end else begin
                        digit_next = digit_inc;
                    end
                end

                PH_FNL: begin
                    phase_next = PH_TAG;
                    if (eoi || ch != CH_LF) begin
                        halted_next    = 1'b1;
                        digit_next     = '0;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_NEWLINE;
                        res.byte_value = eoi ? 8'd0 : ch;
                    end
                end

                PH_KBODY: begin
                    if (eoi || ch == CH_LF) begin
                        halted_next    = 1'b1;
                        phase_next     = PH_TAG;
                        digit_next     = '0;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_DESC;
                        res.byte_value = eoi ? 8'd0 : ch;
                    end else begin
                        remain_next = remain_dec;
                        index_next  = index_inc;
                        if (remain_dec == 16'd0) begin
                            phase_next       = PH_TAG;
                            res_valid        = 1'b1;
                            res.kind         = KIND_DESC_END;
                            res.byte_address = {16'd0,
                                (index_inc < DescMaxW) ? index_inc : DescMaxW};
                            res.byte_value   = (index_reg < DescMaxW) ? ch : 8'd0;
                        end else if (index_reg < DescMaxW) begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_DESC;
                            res.byte_address = {16'd0, index_reg};
                            res.byte_value   = ch;
                        end
                    end
                end

                PH_DRAIN: begin
                    if (eoi) begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_EOI;
                        phase_next = PH_TAG;
                        digit_next = '0;
                    end
                end

                default: begin
                    phase_next = PH_TAG;
                    digit_next = '0;
                end
            endcase
        end

        status.halted = halted_reg;
    end

endmodule

// ----- rtl/thlp_out_reg.sv -----
`timescale 1ns / 1ps
// result register with valid/ready hold toward the receiver
// depends on thlp_pkg
module thlp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  thlp_pkg::result_t res,
    input  logic              m_ready,
    output logic              m_valid,
    output logic              free,
    output thlp_pkg::result_t q
);
    import thlp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb begin
        free       = !valid_reg || m_ready;
        valid_next = valid_reg && !m_ready;
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign q       = data_reg;

endmodule

// ----- rtl/tagged_hex_load_parser.sv -----
`timescale 1ns / 1ps
// top level of the tagged hex load parser: input register, step core, result register
// depends on thlp_pkg, thlp_core, thlp_out_reg
//
// usage
//   input channel (s_): one character per transfer, s_end_of_input marks the
//   end of the stream (s_ch is then ignored)
//   result channel (m_): zero or one result per character: data byte,
//   description byte, description end, end of input, or error with its code
//   path: an accepted character's result reaches m_valid through two register
//   stages (input register, result register)
//   throughput: one character per cycle, sustained, while the receiver keeps up;
//   the step logic is one pass of decode, add and compare per character
//   stall: when the result register holds a result that is not taken, the
//   input register stops advancing; s_ready stays high while the input
//   register is empty, so one more character is absorbed before input stalls
//   errors: one error result, after which characters are still taken but give
//   no result until reset
//   reset: aresetn low clears the parser state, the address and both valids
module tagged_hex_load_parser #(
    parameter int DESC_MAX = thlp_pkg::DESC_MAX_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [31:0] m_byte_address,
    output logic [7:0]  m_byte_value,
    output logic [2:0]  m_error_code,
    output logic [15:0] m_sum_expected,
    output logic [15:0] m_sum_found
);
    import thlp_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_eoi_reg;

    logic    out_free;
    logic    step_en;
    logic    res_valid;
    result_t res;
    result_t out_q;
    status_t status;

    // the held character moves on only when the result register can take its result
    assign step_en = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    // character payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg  <= s_ch;
            in_eoi_reg <= s_end_of_input;
        end
    end

    thlp_core #(
        .DESC_MAX(DESC_MAX)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .ch       (in_ch_reg),
        .eoi      (in_eoi_reg),
        .res_valid(res_valid),
        .res      (res),
        .status   (status)
    );

    thlp_out_reg u_out (
        .aclk   (aclk),
        .aresetn(aresetn),
        .load   (step_en && res_valid),
        .res    (res),
        .m_ready(m_ready),
        .m_valid(m_valid),
        .free   (out_free),
        .q      (out_q)
    );

    // result fields onto their own ports
    assign m_kind         = out_q.kind;
    assign m_byte_address = out_q.byte_address;
    assign m_byte_value   = out_q.byte_value;
    assign m_error_code   = out_q.error_code;
    assign m_sum_expected = out_q.sum_expected;
    assign m_sum_found    = out_q.sum_found;

    // once halted, only reset brings the parser back
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        status.halted |=> status.halted)
        else $error("halted flag dropped without reset");

    // a halted parser produces no results
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !status.halted)
        else $error("result produced while halted");

    // an error code only rides on an error result
    a_err_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_ERROR) |-> (m_error_code == ERR_NONE))
        else $error("error code on a non-error result");

    // input is never stalled while the result register is empty
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

// ----- bench/load_stream_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the tagged hex load parser: watches both channels, parses the
// character stream on its own and compares every result transfer; needs thlp_pkg
module load_stream_checker #(
    parameter int DESC_MAX = thlp_pkg::DESC_MAX_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_input,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_kind,
    input  logic [31:0] m_byte_address,
    input  logic [7:0]  m_byte_value,
    input  logic [2:0]  m_error_code,
    input  logic [15:0] m_sum_expected,
    input  logic [15:0] m_sum_found,
    output int          fail_count,
    output int          pending
);
    import thlp_pkg::*;

    localparam int MAX_REPORTS = 10;

    // parser state
    phase_t      ph;
    logic [3:0]  ndig;
    logic [15:0] acc;
    logic [31:0] addr;
    logic [15:0] lsum;
    logic [15:0] snap;
    logic [15:0] desc_left;
    logic [15:0] desc_pos;
    logic        halted;

    result_t     nxt;
    logic        nxt_valid;
    result_t     parsed_results[$];
    int          mismatches;

    function automatic int digit_value(input logic [7:0] c);
        logic [7:0] up;
        up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        if (up >= "0" && up <= "9") return int'(up - "0");
        if (up >= "A" && up <= "F") return int'(up - "A") + 10;
        return -1;
    endfunction

    task automatic halt_with(input err_t code, input logic [7:0] bad);
        halted = 1'b1;
        ph = PH_TAG;
        ndig = '0;
        nxt.kind = KIND_ERROR;
        nxt.byte_value = bad;
        nxt.error_code = code;
        nxt_valid = 1'b1;
    endtask

    task automatic stream_end();
        ph = PH_TAG;
        ndig = '0;
        nxt.kind = KIND_EOI;
        nxt_valid = 1'b1;
    endtask

    task automatic data_out(input logic [7:0] v);
        nxt.kind = KIND_DATA;
        nxt.byte_address = addr;
        nxt.byte_value = v;
        nxt_valid = 1'b1;
        addr = addr + 32'd1;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic eoi);
        int d;
        logic [15:0] idx;
        nxt = '0;
        nxt_valid = 1'b0;
        if (halted) return;
        if (eoi || c == CH_LF) lsum = '0;
        else lsum = lsum + 16'(c);
        case (ph)
            PH_TAG: begin
                if (eoi) begin
                    stream_end();
                end else begin
                    acc = '0;
                    ndig = '0;
                    case (c)
                        CH_STAR:  ph = PH_STAR;
                        CH_B:     ph = PH_BDATA;
                        CH_0:     ph = PH_HDRW;
                        CH_7: begin
                            snap = ~lsum + 16'd1;
                            ph = PH_CSUM;
                        end
                        CH_8:     ph = PH_SKIPW;
                        CH_9:     ph = PH_ADDR;
                        CH_F:     ph = PH_FNL;
                        CH_K:     ph = PH_KLEN;
                        CH_COLON: ph = PH_DRAIN;
                        default:  halt_with(ERR_TAG, c);
                    endcase
                end
            end
            PH_STAR, PH_BDATA, PH_HDRW, PH_CSUM, PH_SKIPW, PH_ADDR, PH_KLEN: begin
                d = digit_value(c);
                if (eoi) begin
                    halt_with(ERR_TRUNCATED, 8'h00);
                end else if (d < 0) begin
                    halt_with(ERR_HEX, c);
                end else begin
                    acc = {acc[11:0], 4'(d)};
                    ndig = ndig + 4'd1;
                    if (ph == PH_STAR) begin
                        if (ndig == BYTE_DIGITS) begin
                            ph = PH_TAG;
                            data_out(acc[7:0]);
                        end
                    end else if (ph == PH_BDATA) begin
                        if (ndig == BYTE_DIGITS) begin
                            data_out(acc[7:0]);
                        end else if (ndig == WORD_DIGITS) begin
                            ph = PH_TAG;
                            data_out(acc[7:0]);
                        end
                    end else if (ndig == WORD_DIGITS) begin
                        ndig = '0;
                        case (ph)
                            PH_HDRW: ph = PH_HDRN;
                            PH_CSUM: begin
                                if (acc != snap) begin
                                    halt_with(ERR_CHECKSUM, 8'h00);
                                    nxt.sum_expected = snap;
                                    nxt.sum_found = acc;
                                end else begin
                                    ph = PH_TAG;
                                end
                            end
                            PH_ADDR: begin
                                addr = {15'd0, acc, 1'b0};
                                ph = PH_TAG;
                            end
                            PH_KLEN: begin
                                if (acc < DESC_LEN_BIAS) begin
                                    halt_with(ERR_DESC, 8'h00);
                                end else begin
                                    desc_left = acc - DESC_LEN_BIAS;
                                    desc_pos = '0;
                                    if (desc_left == 16'd0) begin
                                        ph = PH_TAG;
                                        nxt.kind = KIND_DESC_END;
                                        nxt_valid = 1'b1;
                                    end else begin
                                        ph = PH_KBODY;
                                    end
                                end
                            end
                            default: ph = PH_TAG;
                        endcase
                    end
                end
            end
            PH_HDRN: begin
                if (eoi) begin
                    stream_end();
                end else begin
                    ndig = ndig + 4'd1;
                    if (ndig >= HDR_NAME_LEN) begin
                        ndig = '0;
                        ph = PH_TAG;
                    end
                end
            end
            PH_FNL: begin
                if (eoi) halt_with(ERR_NEWLINE, 8'h00);
                else if (c != CH_LF) halt_with(ERR_NEWLINE, c);
                else ph = PH_TAG;
            end
            PH_KBODY: begin
                idx = desc_pos;
                if (eoi) begin
                    halt_with(ERR_DESC, 8'h00);
                end else if (c == CH_LF) begin
                    halt_with(ERR_DESC, c);
                end else begin
                    desc_left = desc_left - 16'd1;
                    desc_pos = desc_pos + 16'd1;
                    if (desc_left == 16'd0) begin
                        ph = PH_TAG;
                        nxt.kind = KIND_DESC_END;
                        nxt.byte_address = (desc_pos < DESC_MAX) ? {16'd0, desc_pos}
                                                                 : 32'(DESC_MAX);
                        nxt.byte_value = (idx < DESC_MAX) ? c : 8'h00;
                        nxt_valid = 1'b1;
                    end else if (idx < DESC_MAX) begin
                        nxt.kind = KIND_DESC;
                        nxt.byte_address = {16'd0, idx};
                        nxt.byte_value = c;
                        nxt_valid = 1'b1;
                    end
                end
            end
            PH_DRAIN: begin
                if (eoi) stream_end();
            end
            default: begin
                ph = PH_TAG;
                ndig = '0;
            end
        endcase
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            ph = PH_TAG;
            ndig = '0;
            acc = '0;
            addr = '0;
            lsum = '0;
            snap = '0;
            desc_left = '0;
            desc_pos = '0;
            halted = 1'b0;
            parsed_results.delete();
            mismatches = 0;
        end else begin
            // results first: nothing accepted at this edge can already be out
            if (m_valid && m_ready) begin
                if (parsed_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: kind %0d addr %h value %h err %0d",
                                 m_kind, m_byte_address, m_byte_value, m_error_code);
                end else begin
                    want = parsed_results.pop_front();
                    if (m_kind !== want.kind || m_byte_address !== want.byte_address ||
                        m_byte_value !== want.byte_value ||
                        m_error_code !== want.error_code ||
                        m_sum_expected !== want.sum_expected ||
                        m_sum_found !== want.sum_found) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch, expected: kind %0d addr %h value %h err %0d sums %h %h",
                                     want.kind, want.byte_address, want.byte_value,
                                     want.error_code, want.sum_expected, want.sum_found);
                            $display("            actual: kind %0d addr %h value %h err %0d sums %h %h",
                                     m_kind, m_byte_address, m_byte_value, m_error_code,
                                     m_sum_expected, m_sum_found);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                parse_char(s_ch, s_end_of_input);
                if (nxt_valid) parsed_results.push_back(nxt);
            end
        end
        fail_count <= mismatches;
        pending <= parsed_results.size();
    end

endmodule

// ----- bench/tagged_hex_load_parser_tb.sv -----
`timescale 1ns / 1ps
// top of the tagged hex load parser bench: clock, reset, character stimulus and verdict
// depends on thlp_pkg, tagged_hex_load_parser and load_stream_checker
module tagged_hex_load_parser_tb;
    import thlp_pkg::*;

    localparam int          CYCLE_LIMIT = 1000000;  // far beyond the slowest legal run
    localparam int          ITEM_TARGET = 1150;     // characters before the closing fault
    localparam int          HOLD_AFTER  = 120;      // results taken before the long hold
    localparam int          HOLD_CYCLES = 300;      // length of the long receiver hold
    localparam int          TAIL_CYCLES = 16;       // quiet cycles after the last result
    localparam logic [7:0]  CH_LOWER_A  = "a";
    localparam logic [7:0]  CH_UPPER_A  = "A";

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_ch;
    logic        s_end_of_input;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_kind;
    logic [31:0] m_byte_address;
    logic [7:0]  m_byte_value;
    logic [2:0]  m_error_code;
    logic [15:0] m_sum_expected;
    logic [15:0] m_sum_found;

    int          fail_count;
    int          pending;       // results still owed by the block
    int          cycle_count = 0;
    int          results_taken = 0;
    int          chars_sent;
    logic [15:0] line_sum;      // running line sum of the stream as sent, for checksum words
    logic        feed_steady = 1'b0;   // sender offers back to back while set
    logic        drain_steady = 1'b0;  // receiver takes no random stalls while set

    tagged_hex_load_parser DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_byte_address (m_byte_address),
        .m_byte_value   (m_byte_value),
        .m_error_code   (m_error_code),
        .m_sum_expected (m_sum_expected),
        .m_sum_found    (m_sum_found)
    );

    load_stream_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_byte_address (m_byte_address),
        .m_byte_value   (m_byte_value),
        .m_error_code   (m_error_code),
        .m_sum_expected (m_sum_expected),
        .m_sum_found    (m_sum_found),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle budget, and a new choice of steady or bursty traffic whenever the count's low byte is zero
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[7:0] == 8'd0) begin
            feed_steady <= ($urandom_range(0, 3) == 0);
            drain_steady <= ($urandom_range(0, 3) == 0);
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) results_taken <= results_taken + 1;
    end

    // idle stretch: mostly short, now and then a long one
    function automatic int unsigned pause_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic is_tag(input logic [7:0] c);
        return c == CH_STAR || c == CH_B || c == CH_K || c == CH_7 || c == CH_8 ||
               c == CH_9 || c == CH_COLON || c == CH_0 || c == CH_F;
    endfunction

    // hex digit in either case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_0 + 8'(v);
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 4'd10);
    endfunction

    // any character except newline, for description bodies
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
        return c;
    endfunction

    // one character transfer, then an optional idle gap with valid low
    task automatic send(input logic [7:0] c, input logic eoi);
        int unsigned gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_ch <= c;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
        if (eoi || c == CH_LF) line_sum = '0;
        else line_sum = line_sum + 16'(c);
        gap = (feed_steady || $urandom_range(0, 9) < 7) ? 0 : pause_len();
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send(txt[i], 1'b0);
    endtask

    // four digits, most significant first
    task automatic send_word(input logic [15:0] w);
        for (int i = 3; i >= 0; i--) send(hex_char(w[i*4 +: 4]), 1'b0);
    endtask

    // checksum record whose word matches the negated line sum
    task automatic send_sum_check();
        send(CH_7, 1'b0);
        send_word(~line_sum + 16'd1);
    endtask

    // length word counts the five header characters as well
    task automatic send_desc(input int unsigned body_len);
        send(CH_K, 1'b0);
        send_word(16'(body_len + 5));
        repeat (body_len) send(text_char(), 1'b0);
    endtask

    // header word plus eight free characters, sometimes cut short by the end mark
    task automatic send_header();
        int unsigned n;
        send(CH_0, 1'b0);
        send_word(16'($urandom));
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(0, 7);
            repeat (n) send(8'($urandom_range(0, 255)), 1'b0);
            send(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            repeat (8) send(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // one well-formed record with random content
    task automatic send_record();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send(CH_9, 1'b0);
            send_word(16'($urandom));
        end else if (pick < 26) begin
            send(CH_STAR, 1'b0);
            send(hex_char(4'($urandom)), 1'b0);
            send(hex_char(4'($urandom)), 1'b0);
        end else if (pick < 44) begin
            send(CH_B, 1'b0);
            send_word(16'($urandom));
        end else if (pick < 54) begin
            send_sum_check();
        end else if (pick < 59) begin
            send(CH_8, 1'b0);
            send_word(16'($urandom));
        end else if (pick < 65) begin
            send_header();
        end else if (pick < 73) begin
            send(CH_F, 1'b0);
            send(CH_LF, 1'b0);
        end else if (pick < 85) begin
            // mostly short bodies; a few run near or past the shown limit
            if ($urandom_range(0, 11) == 0) send_desc($urandom_range(249, 262));
            else send_desc($urandom_range(0, 10));
        end else if (pick < 92) begin
            send(CH_COLON, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) send(8'($urandom_range(0, 255)), 1'b0);
            send(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send(8'($urandom_range(0, 255)), 1'b1);  // end mark at a tag
        end
    endtask

    // the single fault of the run; the block halts after it
    task automatic send_fault();
        int unsigned which;
        int unsigned n;
        logic [7:0] c;
        logic [7:0] tag;
        which = $urandom_range(0, 9);
        case (which)
            0: begin  // unknown tag, newline included
                if ($urandom_range(0, 1)) c = CH_LF;
                else do c = 8'($urandom_range(0, 255)); while (is_tag(c));
                send(c, 1'b0);
            end
            1: begin  // checksum word off by one bit
                send(CH_7, 1'b0);
                send_word((~line_sum + 16'd1) ^ (16'd1 << $urandom_range(0, 15)));
            end
            2: begin  // no newline after the end-of-line tag
                send(CH_F, 1'b0);
                send(text_char(), 1'b0);
            end
            3: begin
                send(CH_F, 1'b0);
                send(8'($urandom_range(0, 255)), 1'b1);
            end
            4: begin  // length word below the header size
                send(CH_K, 1'b0);
                send_word(16'($urandom_range(0, 4)));
            end
            5, 6: begin  // description cut by a newline or by the end mark
                n = $urandom_range(1, 6);
                send(CH_K, 1'b0);
                send_word(16'(n + 5));
                repeat ($urandom_range(0, n - 1)) send(text_char(), 1'b0);
                if (which == 5) send(CH_LF, 1'b0);
                else send(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin  // hex field broken by a bad digit or the end mark
                case ($urandom_range(0, 6))
                    0: tag = CH_STAR;
                    1: tag = CH_B;
                    2: tag = CH_0;
                    3: tag = CH_7;
                    4: tag = CH_8;
                    5: tag = CH_9;
                    default: tag = CH_K;
                endcase
                send(tag, 1'b0);
                n = $urandom_range(0, (tag == CH_STAR) ? 1 : 3);
                repeat (n) send(hex_char(4'($urandom)), 1'b0);
                if ($urandom_range(0, 1)) begin
                    do c = 8'($urandom_range(0, 255)); while (is_hex(c));
                    send(c, 1'b0);
                end else begin
                    send(8'($urandom_range(0, 255)), 1'b1);
                end
            end
        endcase
    endtask

    // sender drops valid and holds off until the block has handed over every owed result
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // receiver: random stalls, plus one long hold so the block backs up into its input
    initial begin
        int unsigned stall_left;
        logic hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!drain_steady && $urandom_range(0, 3) == 0) stall_left = pause_len();
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_ch = 8'h00;
        s_end_of_input = 1'b0;
        chars_sent = 0;
        line_sum = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: top address word, byte extremes, mixed-case digits, an empty
        // description, the end-of-line pair, a good checksum and the end mark
        send_text("9ffFF*00BfFa5K0005F\n");
        send_sum_check();
        send(8'($urandom_range(0, 255)), 1'b1);
        wait_drained();

        // random well-formed records, opening with a description near or past the shown limit
        send_desc($urandom_range(249, 262));
        while (chars_sent < ITEM_TARGET) begin
            send_record();
            if (chars_sent >= ITEM_TARGET / 2 && chars_sent < ITEM_TARGET / 2 + 8)
                wait_drained();
        end

        // close with one fault, then characters the halted block must swallow silently
        send_fault();
        repeat (20) send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        @(negedge aclk);
        s_valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
